/* rtl/plt_pkg.sv */
`timescale 1ns / 1ps
// shared constants, codes and types of the ping latency tracker
package plt_pkg;

	localparam int SEQ_W         = 32;
	localparam int TIME_W        = 64;
	localparam int TTL_W         = 36;
	localparam int CNT_W         = 32;
	localparam int EXP_W         = 9;
	localparam int FUNC_W        = 2;
	localparam int STATUS_W      = 3;
	localparam int DEPTH_DEFAULT = 256;

	typedef logic [FUNC_W-1:0]   func_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam logic [TTL_W-1:0] TTL_RESET = 36'd1000000000;
	localparam logic [EXP_W-1:0] EXP_MAX   = '1;

	// item functions
	localparam func_t FUNC_SEND  = 2'd0;
	localparam func_t FUNC_PONG  = 2'd1;
	localparam func_t FUNC_SWEEP = 2'd2;
	localparam func_t FUNC_STATS = 2'd3;

	// result status codes
	localparam status_t ST_SENT    = 3'd0;
	localparam status_t ST_FULL    = 3'd1;
	localparam status_t ST_MATCH   = 3'd2;
	localparam status_t ST_UNKNOWN = 3'd3;
	localparam status_t ST_DONE    = 3'd4;

	// update events toward the statistics counters
	typedef struct packed {
		logic              sample;
		logic              loss;
		logic              clear;
		logic [TIME_W-1:0] rtt;
	} stat_ev_t;

	// current statistics totals
	typedef struct packed {
		logic [TIME_W-1:0] rtt_sum;
		logic [CNT_W-1:0]  samples;
		logic [CNT_W-1:0]  losses;
	} stat_tot_t;

endpackage

/* rtl/plt_ram.sv */
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
module plt_ram #(
	parameter int WIDTH = plt_pkg::TIME_W + 1,
	parameter int DEPTH = plt_pkg::DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/plt_stats.sv */
`timescale 1ns / 1ps
// saturating round-trip sum, sample and loss counters
module plt_stats (
	input  logic               clk,
	input  logic               arst_n,
	input  plt_pkg::stat_ev_t  ev,
	output plt_pkg::stat_tot_t tot
);

	logic [plt_pkg::TIME_W-1:0] rtt_sum_q;
	logic [plt_pkg::CNT_W-1:0]  samples_q;
	logic [plt_pkg::CNT_W-1:0]  losses_q;
	logic [plt_pkg::TIME_W:0]   sum_w;
	logic [plt_pkg::TIME_W-1:0] sum_sat;

	// one carry bit tells overflow
	assign sum_w   = {1'b0, rtt_sum_q} + {1'b0, ev.rtt};
	assign sum_sat = sum_w[plt_pkg::TIME_W] ? '1 : sum_w[plt_pkg::TIME_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtt_sum_q <= '0;
			samples_q <= '0;
			losses_q  <= '0;
		end else begin
			if (ev.clear) begin
				rtt_sum_q <= '0;
				samples_q <= '0;
			end else if (ev.sample) begin
				rtt_sum_q <= sum_sat;
				if (samples_q != '1) begin
					samples_q <= samples_q + 1'b1;
				end
			end
			if (ev.loss && losses_q != '1) begin
				losses_q <= losses_q + 1'b1;
			end
		end
	end

	assign tot.rtt_sum = rtt_sum_q;
	assign tot.samples = samples_q;
	assign tot.losses  = losses_q;

endmodule

/* rtl/plt_ctrl.sv */
`timescale 1ns / 1ps
// window sequencer: head and tail pointers, stamp memory access, result register
module plt_ctrl #(
	parameter int DEPTH = plt_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [plt_pkg::TTL_W-1:0]     ttl,
	// item input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  plt_pkg::func_t                func,
	input  logic [plt_pkg::TIME_W-1:0]    now_ns,
	input  logic [plt_pkg::SEQ_W-1:0]     pong_seq,
	// result output
	output logic                          out_valid,
	input  logic                          out_ready,
	output plt_pkg::status_t              status,
	output logic [plt_pkg::SEQ_W-1:0]     seq_out,
	output logic [plt_pkg::TIME_W-1:0]    rtt_ns,
	output logic [plt_pkg::EXP_W-1:0]     expired_count,
	output logic [plt_pkg::TIME_W-1:0]    rtt_total,
	output logic [plt_pkg::CNT_W-1:0]     sample_total,
	output logic [plt_pkg::CNT_W-1:0]     loss_total,
	// stamp memory
	output logic                          mem_we,
	output logic [$clog2(DEPTH)-1:0]      mem_waddr,
	output logic [plt_pkg::TIME_W:0]      mem_wdata,
	output logic                          mem_re,
	output logic [$clog2(DEPTH)-1:0]      mem_raddr,
	input  logic [plt_pkg::TIME_W:0]      mem_rdata,
	// statistics
	output plt_pkg::stat_ev_t             stat_ev,
	input  plt_pkg::stat_tot_t            stat_tot
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam int TW = plt_pkg::TIME_W;
	localparam int SW = plt_pkg::SEQ_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_PWAIT = 3'd2;
	localparam logic [2:0] S_PUPD  = 3'd3;
	localparam logic [2:0] S_HREAD = 3'd4;
	localparam logic [2:0] S_HEVAL = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]    state_q;
	logic [SW-1:0] next_seq_q;
	logic [SW-1:0] oldest_seq_q;
	logic [AW-1:0] oldest_slot_q;
	logic [CW-1:0] count_q;
	logic          out_valid_q;

	// item and work registers
	plt_pkg::func_t  func_q;
	logic [TW-1:0]   now_q;
	logic [SW-1:0]   pseq_q;
	logic [SW-1:0]   off_q;
	logic [AW-1:0]   slot_q;
	logic [TW-1:0]   stamp_q;
	logic [TW-1:0]   rtt_q;

	// pending result
	plt_pkg::status_t          res_status_q;
	logic [SW-1:0]             res_seq_q;
	logic [TW-1:0]             res_rtt_q;
	logic [plt_pkg::EXP_W-1:0] res_exp_q;
	plt_pkg::stat_tot_t        res_tot_q;

	// output register
	plt_pkg::status_t          o_status_q;
	logic [SW-1:0]             o_seq_q;
	logic [TW-1:0]             o_rtt_q;
	logic [plt_pkg::EXP_W-1:0] o_exp_q;
	plt_pkg::stat_tot_t        o_tot_q;

	logic          accept;
	logic          out_load;
	logic          full;
	logic          win_hit;
	logic [AW-1:0] off_slot;
	logic [AW-1:0] tail_slot;
	logic [AW-1:0] head_next;
	logic          rd_valid;
	logic [TW-1:0] rd_stamp;
	logic [TW:0]   diff;
	logic          late;
	logic [TW-1:0] elapsed_w;
	logic          expired;
	logic          drop;
	logic          advance;

	// ring slot of an offset from the head, depth need not be a power of two
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
						  input logic [AW-1:0] ofs);
		logic [CW-1:0] s;
		s = {1'b0, base} + {1'b0, ofs};
		if (s >= DEPTH_C) begin
			s = s - DEPTH_C;
		end
		return s[AW-1:0];
	endfunction

	assign accept   = (state_q == S_IDLE) && in_valid;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == S_IDLE);

	assign full      = (count_q == DEPTH_C);
	assign win_hit   = (off_q < SW'(count_q));
	assign off_slot  = slot_of(oldest_slot_q, off_q[AW-1:0]);
	assign tail_slot = slot_of(oldest_slot_q, count_q[AW-1:0]);
	assign head_next = slot_of(oldest_slot_q, AW'(1));

	// age of the entry just read, clamped at zero when time went backwards
	assign rd_valid  = mem_rdata[TW];
	assign rd_stamp  = mem_rdata[TW-1:0];
	assign diff      = {1'b0, now_q} - {1'b0, rd_stamp};
	assign late      = diff[TW];
	assign elapsed_w = late ? '0 : diff[TW-1:0];
	assign expired   = !late && (diff[TW-1:0] > TW'(ttl));

	// head walk: freed entries always retire, valid ones only when a sweep finds them stale
	assign drop    = (state_q == S_HEVAL) && (func_q == plt_pkg::FUNC_SWEEP)
			 && rd_valid && expired;
	assign advance = (state_q == S_HEVAL) && (!rd_valid || drop);

	// memory port use
	assign mem_we    = ((state_q == S_DISP) && (func_q == plt_pkg::FUNC_SEND) && !full)
			   || (state_q == S_PUPD);
	assign mem_waddr = (state_q == S_PUPD) ? slot_q : tail_slot;
	assign mem_wdata = (state_q == S_PUPD) ? {1'b0, stamp_q} : {1'b1, now_q};
	assign mem_re    = ((state_q == S_DISP) && (func_q == plt_pkg::FUNC_PONG))
			   || (state_q == S_HREAD);
	assign mem_raddr = (state_q == S_HREAD) ? oldest_slot_q : off_slot;

	assign stat_ev.sample = (state_q == S_PUPD);
	assign stat_ev.loss   = drop;
	assign stat_ev.clear  = (state_q == S_DISP) && (func_q == plt_pkg::FUNC_STATS);
	assign stat_ev.rtt    = rtt_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			next_seq_q    <= '0;
			oldest_seq_q  <= '0;
			oldest_slot_q <= '0;
			count_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (func_q)
						plt_pkg::FUNC_SEND: begin
							if (!full) begin
								next_seq_q <= next_seq_q + 1'b1;
								count_q    <= count_q + 1'b1;
							end
							state_q <= S_DONE;
						end
						plt_pkg::FUNC_PONG: begin
							state_q <= win_hit ? S_PWAIT : S_DONE;
						end
						plt_pkg::FUNC_SWEEP: begin
							state_q <= S_HREAD;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_PWAIT: begin
					state_q <= rd_valid ? S_PUPD : S_DONE;
				end
				S_PUPD: begin
					state_q <= S_HREAD;
				end
				S_HREAD: begin
					state_q <= (count_q == '0) ? S_DONE : S_HEVAL;
				end
				S_HEVAL: begin
					if (advance) begin
						oldest_seq_q  <= oldest_seq_q + 1'b1;
						oldest_slot_q <= head_next;
						count_q       <= count_q - 1'b1;
						state_q       <= S_HREAD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			now_q  <= now_ns;
			pseq_q <= pong_seq;
			off_q  <= pong_seq - oldest_seq_q;
		end
		case (state_q)
			S_DISP: begin
				res_seq_q <= '0;
				res_rtt_q <= '0;
				res_exp_q <= '0;
				res_tot_q <= '0;
				case (func_q)
					plt_pkg::FUNC_SEND: begin
						if (full) begin
							res_status_q <= plt_pkg::ST_FULL;
						end else begin
							res_status_q <= plt_pkg::ST_SENT;
							res_seq_q    <= next_seq_q;
						end
					end
					plt_pkg::FUNC_PONG: begin
						res_status_q <= plt_pkg::ST_UNKNOWN;
						slot_q       <= off_slot;
					end
					plt_pkg::FUNC_SWEEP: begin
						res_status_q <= plt_pkg::ST_DONE;
					end
					default: begin
						res_status_q <= plt_pkg::ST_DONE;
						res_tot_q    <= stat_tot;
					end
				endcase
			end
			S_PWAIT: begin
				stamp_q <= rd_stamp;
				rtt_q   <= elapsed_w;
			end
			S_PUPD: begin
				res_status_q <= plt_pkg::ST_MATCH;
				res_seq_q    <= pseq_q;
				res_rtt_q    <= rtt_q;
			end
			S_HEVAL: begin
				if (drop && res_exp_q != plt_pkg::EXP_MAX) begin
					res_exp_q <= res_exp_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			o_status_q <= res_status_q;
			o_seq_q    <= res_seq_q;
			o_rtt_q    <= res_rtt_q;
			o_exp_q    <= res_exp_q;
			o_tot_q    <= res_tot_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = o_status_q;
	assign seq_out       = o_seq_q;
	assign rtt_ns        = o_rtt_q;
	assign expired_count = o_exp_q;
	assign rtt_total     = o_tot_q.rtt_sum;
	assign sample_total  = o_tot_q.samples;
	assign loss_total    = o_tot_q.losses;

endmodule

/* rtl/ping_latency_tracker_core.sv */
`timescale 1ns / 1ps
// top level of the ping latency tracker
//
// keeps a ring of up to DEPTH outstanding pings keyed by a 32-bit wrapping
// sequence number; each entry is one word of a DEPTH x 65 stamp memory (valid
// bit plus send time). a send item stamps the tail slot, a pong item reads
// its slot and returns the round trip, an expiry tick walks the head dropping
// pings older than ttl_ns, a stats item reads and clears the sum and sample
// count. one item is in work at a time. send, stats and an out-of-window pong
// go straight from dispatch to the result; an in-window pong whose entry was
// already answered ends after its read; a matched pong frees its entry, then
// walks the head, retiring freed entries; an expiry tick walks the head,
// retiring freed entries and dropping stale ones; both head walks stop at the
// first entry they keep or when the window is empty. the stamp memory has a
// single read port, so every head entry inspected takes a read state and
// then an evaluate state. a result waits in an output register, so the next
// item is taken while it is still unread; a result that is still unread when
// the next one is ready holds the block until out_ready. no clearing pass is
// needed after reset: only slots inside the window are ever used, and each of
// those was written by its send. the user must write ttl_ns through cfg_wr_en
// and cfg_wr_data only while the block is idle; the block does not enforce it.
module ping_latency_tracker_core #(
	parameter int DEPTH = plt_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// ttl register write
	input  logic                          cfg_wr_en,
	input  logic [plt_pkg::TTL_W-1:0]     cfg_wr_data,
	// item input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  plt_pkg::func_t                func,
	input  logic [plt_pkg::TIME_W-1:0]    now_ns,
	input  logic [plt_pkg::SEQ_W-1:0]     pong_seq,
	// result output
	output logic                          out_valid,
	input  logic                          out_ready,
	output plt_pkg::status_t              status,
	output logic [plt_pkg::SEQ_W-1:0]     seq_out,
	output logic [plt_pkg::TIME_W-1:0]    rtt_ns,
	output logic [plt_pkg::EXP_W-1:0]     expired_count,
	output logic [plt_pkg::TIME_W-1:0]    rtt_total,
	output logic [plt_pkg::CNT_W-1:0]     sample_total,
	output logic [plt_pkg::CNT_W-1:0]     loss_total
);

	localparam int AW = $clog2(DEPTH);

	// ttl register, a ping is lost when its age is strictly greater than this value
	logic [plt_pkg::TTL_W-1:0] ttl_q;

	// stamp memory port
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [plt_pkg::TIME_W:0]  mem_wdata;
	logic                      mem_re;
	logic [AW-1:0]             mem_raddr;
	logic [plt_pkg::TIME_W:0]  mem_rdata;

	plt_pkg::stat_ev_t  stat_ev;
	plt_pkg::stat_tot_t stat_tot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= plt_pkg::TTL_RESET;
		end else if (cfg_wr_en) begin
			ttl_q <= cfg_wr_data;
		end
	end

	// {valid, send time} per ring slot
	plt_ram #(
		.WIDTH (plt_pkg::TIME_W + 1),
		.DEPTH (DEPTH)
	) u_stamps (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// saturating totals
	plt_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.ev     (stat_ev),
		.tot    (stat_tot)
	);

	// window sequencer and result register
	plt_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.ttl           (ttl_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.now_ns        (now_ns),
		.pong_seq      (pong_seq),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.seq_out       (seq_out),
		.rtt_ns        (rtt_ns),
		.expired_count (expired_count),
		.rtt_total     (rtt_total),
		.sample_total  (sample_total),
		.loss_total    (loss_total),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata),
		.stat_ev       (stat_ev),
		.stat_tot      (stat_tot)
	);

	// one item in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in work");

	// a round trip is only reported for a matched pong
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rtt_ns != '0) |-> (status == plt_pkg::ST_MATCH))
		else $error("round trip on a result that is not a match");

	// drops are only reported by a finished sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && expired_count != '0) |-> (status == plt_pkg::ST_DONE))
		else $error("drop count on a result that is not a sweep");

	// totals are only reported by a finished stats read
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (sample_total != '0 || loss_total != '0))
		|-> (status == plt_pkg::ST_DONE))
		else $error("totals on a result that is not a stats read");

endmodule
